// ===== src/sha1md_pkg.sv =====
// Shared types and constants for the SHA-1 message digest block.
`timescale 1ns / 1ps

package sha1md_pkg;

    localparam int HASH_WORDS  = 5;
    localparam int WIN_WORDS   = 16;
    localparam int ROUNDS      = 80;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // one queued message word; on the last entry data already holds the pad byte
    typedef struct packed {
        logic        last;
        logic [1:0]  nbytes;
        logic [31:0] data;
    } qent_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN_LO,
        ST_OUT
    } core_state_t;

endpackage

// ===== src/sha1md_front.sv =====
// Byte intake: packs message bytes into big-endian words and marks the tail.
`timescale 1ns / 1ps

module sha1md_front
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        push_valid,
    output qent_t       push_data,
    input  logic        q_full
);

    logic [1:0]  nb_reg, nb_next;
    logic        pend_reg, pend_next;
    logic [23:0] acc_reg, acc_next;
    logic [23:0] acc_cur;
    logic [1:0]  nb_cur;
    logic        accept;
    logic        word_done;

    function automatic logic [31:0] pad_word(input logic [23:0] acc, input logic [1:0] nb);
        logic [31:0] w;
        case (nb)
            2'd0:    w = {PAD_BYTE, 24'h0};
            2'd1:    w = {acc[7:0], PAD_BYTE, 16'h0};
            2'd2:    w = {acc[15:0], PAD_BYTE, 8'h0};
            2'd3:    w = {acc[23:0], PAD_BYTE};
            default: w = {PAD_BYTE, 24'h0};
        endcase
        return w;
    endfunction

    assign in_ready  = !pend_reg && !q_full;
    assign accept    = in_valid && in_ready;
    assign acc_cur   = byte_present ? {acc_reg[15:0], data_byte} : acc_reg;
    assign nb_cur    = nb_reg + {1'b0, byte_present};
    assign word_done = byte_present && (nb_reg == 2'd3);

    always_comb
    begin
        nb_next    = nb_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        push_valid = 1'b0;
        push_data  = '{last: 1'b0, nbytes: 2'd0, data: {acc_reg, data_byte}};
        if (pend_reg)
        begin
            push_valid = !q_full;
            push_data  = '{last: 1'b1, nbytes: 2'd0, data: pad_word(acc_reg, 2'd0)};
            if (!q_full)
            begin
                pend_next = 1'b0;
            end
        end
        else if (accept)
        begin
            acc_next = acc_cur;
            if (word_done)
            begin
                push_valid = 1'b1;
                nb_next    = 2'd0;
                pend_next  = message_end;
            end
            else if (message_end)
            begin
                push_valid = 1'b1;
                push_data  = '{last: 1'b1, nbytes: nb_cur, data: pad_word(acc_cur, nb_cur)};
                nb_next    = 2'd0;
            end
            else
            begin
                nb_next = nb_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg   <= 2'd0;
            pend_reg <= 1'b0;
        end
        else
        begin
            nb_reg   <= nb_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

// ===== src/sha1md_queue.sv =====
// Short word queue between the byte intake and the compression engine.
`timescale 1ns / 1ps

module sha1md_queue
    import sha1md_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  qent_t push_data,
    output logic  full,
    output logic  pop_valid,
    input  logic  pop_ready,
    output qent_t pop_data
);

    qent_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_reg, wr_next;
    logic [QUEUE_AW-1:0]   rd_reg, rd_next;
    logic [QUEUE_AW:0]     cnt_reg, cnt_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + {{QUEUE_AW{1'b0}}, do_push} - {{QUEUE_AW{1'b0}}, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ===== src/sha1md_core.sv =====
// Compression engine: schedule window, 80-round loop, padding, length and digest output.
`timescale 1ns / 1ps

module sha1md_core
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  qent_t       pop_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        final_word
);

    core_state_t state_reg, state_next;
    logic [31:0] h_reg [HASH_WORDS];
    logic [31:0] h_next [HASH_WORDS];
    logic [31:0] v_reg [HASH_WORDS];
    logic [31:0] v_next [HASH_WORDS];
    logic [31:0] w_reg [WIN_WORDS];
    logic [31:0] w_next [WIN_WORDS];
    logic [63:0] bits_reg, bits_next;
    logic [3:0]  wcnt_reg, wcnt_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic        len_reg, len_next;

    logic        push_en;
    logic [31:0] push_word;
    logic [31:0] sched;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_sum;

    assign digest_word = h_reg[idx_reg];
    assign word_number = idx_reg;
    assign final_word  = (idx_reg == 3'(HASH_WORDS - 1));
    assign out_valid   = (state_reg == ST_OUT);

    always_comb
    begin
        sched = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        sched = {sched[30:0], sched[31]};
        if (rnd_reg < 7'd20)
        begin
            f_val = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            k_val = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3]) | (v_reg[2] & v_reg[3]);
            k_val = K2;
        end
        else
        begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = K3;
        end
        t_sum = {v_reg[0][26:0], v_reg[0][31:27]} + f_val + v_reg[4] + w_reg[0] + k_val;
    end

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        bits_next  = bits_reg;
        wcnt_next  = wcnt_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        pop_ready  = 1'b0;
        push_en    = 1'b0;
        push_word  = pop_data.data;

        case (state_reg)
            ST_LOAD:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    push_en   = 1'b1;
                    bits_next = bits_reg + (pop_data.last ? {59'd0, pop_data.nbytes, 3'd0}
                                                          : 64'd32);
                    fin_next  = pop_data.last;
                    if (wcnt_reg == 4'd15)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (pop_data.last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < WIN_WORDS - 1; i++)
                begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[WIN_WORDS-1] = sched;
                v_next[0] = t_sum;
                v_next[1] = v_reg[0];
                v_next[2] = {v_reg[1][1:0], v_reg[1][31:2]};
                v_next[3] = v_reg[2];
                v_next[4] = v_reg[3];
                rnd_next  = rnd_reg + 1'b1;
                if (rnd_reg == 7'(ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                if (fin_reg && len_reg)
                begin
                    state_next = ST_OUT;
                    idx_next   = 3'd0;
                end
                else if (fin_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_PAD:
            begin
                push_en   = 1'b1;
                push_word = (wcnt_reg == 4'd14) ? bits_reg[63:32] : 32'd0;
                if (wcnt_reg == 4'd15)
                begin
                    state_next = ST_ROUND;
                end
                else if (wcnt_reg == 4'd14)
                begin
                    state_next = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                push_en    = 1'b1;
                push_word  = bits_reg[31:0];
                len_next   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == 3'(HASH_WORDS - 1))
                    begin
                        h_next     = H_INIT;
                        bits_next  = 64'd0;
                        fin_next   = 1'b0;
                        len_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (push_en)
        begin
            for (int i = 0; i < WIN_WORDS - 1; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[WIN_WORDS-1] = push_word;
            wcnt_next = wcnt_reg + 1'b1;
            if (wcnt_reg == 4'd15)
            begin
                v_next   = h_reg;
                rnd_next = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            h_reg     <= H_INIT;
            bits_reg  <= 64'd0;
            wcnt_reg  <= 4'd0;
            rnd_reg   <= 7'd0;
            idx_reg   <= 3'd0;
            fin_reg   <= 1'b0;
            len_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            bits_reg  <= bits_next;
            wcnt_reg  <= wcnt_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

endmodule

// ===== src/sha1_message_digest.sv =====
// SHA-1 message digest, one message byte per input word, five digest words out.
// Bytes are taken one per cycle while s_tready is high, into an eight-word queue; each
// 64-byte block then needs 16 queue pops, then 80 rounds and the chaining add.
// Sustained input rate is set by the single round unit. Message end pads the last block
// and may add one more; then five output words, one per cycle while m_tready is high.
// rst_n is asynchronous: it loads the initial chaining values and empties the queue.
`timescale 1ns / 1ps

module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_number
    output logic        m_tlast
);

    logic  push_valid;
    qent_t push_data;
    logic  q_full;
    logic  pop_valid;
    logic  pop_ready;
    qent_t pop_data;

    sha1md_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .data_byte    (s_tdata),
        .byte_present (s_tuser),
        .message_end  (s_tlast),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    sha1md_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sha1md_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .digest_word (m_tdata),
        .word_number (m_tuser),
        .final_word  (m_tlast)
    );

endmodule
